FILE: sv/prq_pkg.sv
package prq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned PRI_W     = 16;
	localparam int unsigned OCC_W     = 5;
	localparam int unsigned STAT_W    = 2;

	// request codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [PRI_W-1:0] pri;
	} entry_t;

	// running minimum handed down the row
	typedef struct packed {
		logic   vld;
		entry_t ent;
	} carry_t;

	// row-wide shift commands
	typedef struct packed {
		logic push;    // every cell takes its left neighbor
		logic remove;  // cells at or behind the winner take their right neighbor
	} cell_ctrl_t;

endpackage

FILE: sv/priority_ready_queue_top.sv
// Priority ready queue: keeps up to QUEUE_DEPTH (thread id, priority) requests
// in a row of cells, the front in cell 0. A push request (action 0) inserts at
// the front; a pop request (action 1) removes the entry with the lowest signed
// priority, the one nearest the front among equals (LIFO on ties). A request is
// taken on a clock edge with start high and busy low. Each request gives one
// result, shown for exactly one cycle with done high; the receiver cannot stall
// it, so it must take it then. Push, push to a full queue and pop from an empty
// queue: the result appears in the cycle after the request edge and busy stays
// low, so a request may follow every cycle. Pop on a non-empty queue: busy is
// high while the running minimum moves through the cell row one cell per
// clock, and the result appears once it has reached the last cell, so no new
// request is taken until then. A new request may be given in the same cycle
// that a result is shown. occupancy is the entry count after the request, kept
// to its low five bits.
module priority_ready_queue_top #(
	parameter int unsigned QUEUE_DEPTH = prq_pkg::DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  action,
	input  logic [prq_pkg::ID_W-1:0]              thread_id,
	input  logic signed [prq_pkg::PRI_W-1:0]      priority_req,
	output logic                                  done,
	output logic [prq_pkg::STAT_W-1:0]            status,
	output logic [prq_pkg::ID_W-1:0]              popped_id,
	output logic signed [prq_pkg::PRI_W-1:0]      popped_priority,
	output logic [prq_pkg::OCC_W-1:0]             occupancy
);
	import prq_pkg::*;

	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// controller states
	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic          state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] scan_cnt_q;
	logic          done_q;
	logic [STAT_W-1:0]        status_q;
	logic [ID_W-1:0]          pid_q;
	logic signed [PRI_W-1:0]  ppri_q;

	logic       accept;
	logic       is_full;
	logic       is_empty;
	logic       scan_last;
	cell_ctrl_t ctrl;
	entry_t     new_ent;

	entry_t        ent      [QUEUE_DEPTH];
	carry_t        carry    [QUEUE_DEPTH];
	logic [IW-1:0] carry_idx[QUEUE_DEPTH];

	assign accept    = start && !busy;
	assign is_full   = count_q == CW'(QUEUE_DEPTH);
	assign is_empty  = count_q == '0;
	assign scan_last = (state_q == S_SCAN) && (scan_cnt_q == '0);

	// row commands: push shifts everything back one cell, the end of a pop
	// scan closes the gap behind the winner
	assign ctrl.push   = accept && (action == ACT_PUSH) && !is_full;
	assign ctrl.remove = scan_last;

	assign new_ent.id  = thread_id;
	assign new_ent.pri = priority_req;

	// the cell row; the running minimum at the last cell names the winner
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t        left_w;
		entry_t        right_w;
		carry_t        cin_w;
		logic [IW-1:0] cin_idx_w;

		if (i == 0) begin : g_head
			assign left_w    = new_ent;
			assign cin_w     = '0;
			assign cin_idx_w = '0;
		end else begin : g_body
			assign left_w    = ent[i-1];
			assign cin_w     = carry[i-1];
			assign cin_idx_w = carry_idx[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_w = ent[i];
		end else begin : g_mid
			assign right_w = ent[i+1];
		end

		prq_cell #(
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.IDX        (i)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.left         (left_w),
			.right        (right_w),
			.ent          (ent[i]),
			.carry_in     (cin_w),
			.carry_in_idx (cin_idx_w),
			.carry_out    (carry[i]),
			.carry_out_idx(carry_idx[i]),
			.count        (count_q),
			.best_idx     (carry_idx[QUEUE_DEPTH-1])
		);
	end

	// control: the queue holds still during a scan, so by the end of the scan
	// the tail carry holds the front-most minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_PUSH) begin
							done_q <= 1'b1;
							if (!is_full) begin
								count_q <= count_q + 1'b1;
							end
						end else if (is_empty) begin
							done_q <= 1'b1;
						end else begin
							state_q    <= S_SCAN;
							scan_cnt_q <= IW'(QUEUE_DEPTH - 1);
						end
					end
				end
				S_SCAN: begin
					if (scan_cnt_q == '0) begin
						state_q <= S_IDLE;
						count_q <= count_q - 1'b1;
						done_q  <= 1'b1;
					end else begin
						scan_cnt_q <= scan_cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (scan_last) begin
			status_q <= STAT_OK;
			pid_q    <= carry[QUEUE_DEPTH-1].ent.id;
			ppri_q   <= carry[QUEUE_DEPTH-1].ent.pri;
		end else if (accept) begin
			pid_q  <= '0;
			ppri_q <= '0;
			if (action == ACT_PUSH) begin
				status_q <= is_full ? STAT_FULL : STAT_OK;
			end else begin
				status_q <= STAT_EMPTY;
			end
		end
	end

	assign busy            = state_q == S_SCAN;
	assign done            = done_q;
	assign status          = status_q;
	assign popped_id       = pid_q;
	assign popped_priority = ppri_q;
	assign occupancy       = OCC_W'(count_q);

	// count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// push on a full queue is refused at once and leaves the count alone
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_PUSH) && is_full)
		|=> (done && (status == STAT_FULL) && $stable(count_q)))
		else $error("full push not refused");

	// pop on an empty queue answers at once without a scan
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_POP) && is_empty)
		|=> (done && (status == STAT_EMPTY) && (state_q == S_IDLE)))
		else $error("empty pop not answered");

	// end of a scan removes exactly one entry and reports it
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		scan_last |=> (done && (status == STAT_OK)
		&& (count_q == $past(count_q) - 1'b1)))
		else $error("pop did not remove one entry");

	// a scan always carries a valid minimum to the tail
	a_scan_valid: assert property (@(posedge clk) disable iff (!arst_n)
		scan_last |-> carry[QUEUE_DEPTH-1].vld)
		else $error("scan ended without a winner");

endmodule

FILE: sv/prq_cell.sv
module prq_cell #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned IDX = 0,
	localparam int unsigned IW = $clog2(QUEUE_DEPTH),
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  prq_pkg::cell_ctrl_t ctrl,
	input  prq_pkg::entry_t     left,
	input  prq_pkg::entry_t     right,
	output prq_pkg::entry_t     ent,
	input  prq_pkg::carry_t     carry_in,
	input  logic [IW-1:0]       carry_in_idx,
	output prq_pkg::carry_t     carry_out,
	output logic [IW-1:0]       carry_out_idx,
	input  logic [CW-1:0]       count,
	input  logic [IW-1:0]       best_idx
);
	import prq_pkg::*;

	entry_t        ent_q;
	carry_t        carry_q;
	logic [IW-1:0] carry_idx_q;
	logic          occupied;
	logic          take_own;

	assign occupied = CW'(IDX) < count;
	// strict compare: an earlier (front) entry keeps ties
	assign take_own = occupied && (!carry_in.vld || (ent_q.pri < carry_in.ent.pri));

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			ent_q <= left;
		end else if (ctrl.remove && (IW'(IDX) >= best_idx)) begin
			ent_q <= right;
		end
	end

	always_ff @(posedge clk) begin
		if (take_own) begin
			carry_q.vld <= 1'b1;
			carry_q.ent <= ent_q;
			carry_idx_q <= IW'(IDX);
		end else begin
			carry_q     <= carry_in;
			carry_idx_q <= carry_in_idx;
		end
	end

	assign ent           = ent_q;
	assign carry_out     = carry_q;
	assign carry_out_idx = carry_idx_q;

endmodule
